// ===== rtl/core/hhp_pkg.sv =====
package hhp_pkg;

    // Byte codes the parser looks for
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int          OFFSET_W     = 16;
    localparam logic [15:0] LIMIT_RESET  = 16'd255;
    localparam logic [15:0] OFFSET_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_KEY    = 4'd1,
        PH_COLON  = 4'd2,
        PH_SPACE  = 4'd3,
        PH_VALUE  = 4'd4,
        PH_CR     = 4'd5,
        PH_LF     = 4'd6,
        PH_END_CR = 4'd7,
        PH_DONE   = 4'd8,
        PH_ERROR  = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        K_IGNORED = 3'd0,
        K_KEY     = 3'd1,
        K_VALUE   = 3'd2,
        K_FIELD   = 3'd3,
        K_HEADERS = 3'd4,
        K_ERROR   = 3'd5,
        K_AFTER   = 3'd6
    } kind_t;

    typedef enum logic {
        FN_PARSE   = 1'b0,
        FN_RESTART = 1'b1
    } func_t;

endpackage

// ===== rtl/core/http_header_byte_parser.sv =====
// Each input transfer loads its result into the single output register, which
// refills while it is taken. Throughput: one byte per cycle while the output is
// not stalled; the phase and offset registers update at the input transfer.
// Reset: phase goes to start, offset to zero, limit to 255, output register empty.
// A restart item returns phase and offset to reset values but keeps the limit.
module http_header_byte_parser
    import hhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  byte_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  byte_out,
    output logic [3:0]  phase_out
);

    logic [OFFSET_W-1:0] limit_reg;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    kind_t               kind_next;
    logic [OFFSET_W:0]   offset_inc;
    logic                in_xfer;

    logic                out_valid_reg;
    kind_t               kind_reg;
    logic [7:0]          byte_reg;
    phase_t              phase_out_reg;

    // Accept whenever the output register is empty or drains this cycle
    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign offset_inc = {1'b0, offset_reg} + {{OFFSET_W{1'b0}}, 1'b1};

    // Next phase, offset and tag for the byte at the input
    always_comb
    begin
        phase_next  = phase_reg;
        offset_next = offset_reg;
        kind_next   = K_IGNORED;
        if (func == FN_RESTART)
        begin
            phase_next  = PH_START;
            offset_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (byte_in != CH_CR && byte_in != CH_LF)
                    begin
                        phase_next = PH_KEY;
                        kind_next  = K_KEY;
                    end
                end
                PH_KEY:
                begin
                    if (byte_in == CH_COLON)
                        phase_next = PH_COLON;
                    else if (byte_in == CH_CR || byte_in == CH_LF)
                    begin
                        phase_next = PH_ERROR;
                        kind_next  = K_ERROR;
                    end
                    else
                        kind_next = K_KEY;
                end
                PH_COLON:
                begin
                    if (byte_in == CH_SPACE)
                        phase_next = PH_SPACE;
                    else
                    begin
                        phase_next = PH_ERROR;
                        kind_next  = K_ERROR;
                    end
                end
                PH_SPACE:
                begin
                    phase_next  = PH_VALUE;
                    offset_next = '0;
                    kind_next   = K_VALUE;
                end
                PH_VALUE:
                begin
                    if (byte_in == CH_CR)
                        phase_next = PH_CR;
                    else if (offset_inc > {1'b0, limit_reg})
                    begin
                        phase_next = PH_ERROR;
                        kind_next  = K_ERROR;
                    end
                    else
                    begin
                        // Saturate the stored offset
                        offset_next = offset_inc[OFFSET_W] ? OFFSET_MAX
                                                           : offset_inc[OFFSET_W-1:0];
                        kind_next   = K_VALUE;
                    end
                end
                PH_CR:
                begin
                    if (byte_in == CH_LF)
                    begin
                        phase_next = PH_LF;
                        kind_next  = K_FIELD;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        kind_next  = K_ERROR;
                    end
                end
                PH_LF:
                begin
                    if (byte_in == CH_CR)
                        phase_next = PH_END_CR;
                    else
                    begin
                        phase_next = PH_KEY;
                        kind_next  = K_KEY;
                    end
                end
                PH_END_CR:
                begin
                    if (byte_in == CH_LF)
                    begin
                        phase_next = PH_DONE;
                        kind_next  = K_HEADERS;
                    end
                    else
                    begin
                        phase_next = PH_ERROR;
                        kind_next  = K_ERROR;
                    end
                end
                PH_DONE:
                begin
                    kind_next = K_AFTER;
                end
                default:
                begin
                    phase_next = PH_ERROR;
                    kind_next  = K_ERROR;
                end
            endcase
        end
    end

    // Hold the offset limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    // Advance parser state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            offset_reg <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            kind_reg      <= kind_next;
            byte_reg      <= (func == FN_RESTART) ? 8'd0 : byte_in;
            phase_out_reg <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign byte_out  = byte_reg;
    assign phase_out = phase_out_reg;

`ifndef SYNTHESIS
    // Headers complete always leaves the parser done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == K_HEADERS |-> phase_out_reg == PH_DONE)
    else $error("headers complete without done phase");

    // An error tag always leaves the parser in the error phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == K_ERROR |-> phase_out_reg == PH_ERROR)
    else $error("error tag without error phase");

    // Done is sticky: later data bytes are tagged after end
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == FN_PARSE && phase_reg == PH_DONE
        |=> kind_reg == K_AFTER && phase_reg == PH_DONE)
    else $error("done phase not sticky");

    // Restart clears phase and offset
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == FN_RESTART |=> phase_reg == PH_START && offset_reg == '0)
    else $error("restart did not clear state");

    // Result register tracks the parser phase
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid_reg && phase_out_reg == phase_reg)
    else $error("result phase out of step");
`endif

endmodule
